// File: rtl/gbc_pkg.sv
package gbc_pkg;

  localparam int RAW_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int RATE_W   = 32;
  localparam int PROD_W   = RAW_W + GAIN_W + 1;
  localparam int SUM_W    = 36;
  localparam int STAMP_W  = 63;
  localparam int CNT_W    = 4;
  localparam int LIMIT_W  = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int NUM_AXES = 3;

  localparam logic [1:0] ACT_SAMPLE  = 2'd0;
  localparam logic [1:0] ACT_SYNC    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ROLL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PITCH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_YAW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_LIMIT = 3'd4;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd20500;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd8388608;

  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_SYNC,
    CMD_RESTART
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [1:0]                axis;
    logic signed [RAW_W-1:0]   raw;
    logic                      moving;
    logic [STAMP_W-1:0]        stamp;
  } cmd_t;

  typedef struct packed {
    logic                enable;
    logic [GAIN_W-1:0]   gain_x;
    logic [GAIN_W-1:0]   gain_y;
    logic [GAIN_W-1:0]   gain_z;
    logic [LIMIT_W-1:0]  bias_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SYNC,
    ST_DIV,
    ST_CHECK,
    ST_EMIT
  } back_state_t;

endpackage

// File: rtl/gbc_fifo.sv
module gbc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// File: rtl/gbc_front.sv
module gbc_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [1:0]                    in_axis,
  input  logic signed [gbc_pkg::RAW_W-1:0] in_raw_value,
  input  logic                          in_moving,
  input  logic [gbc_pkg::STAMP_W-1:0]   in_stamp,
  input  logic                          q_full,
  output logic                          q_push,
  output gbc_pkg::cmd_t                 q_cmd
);

  import gbc_pkg::*;

  logic keep;

  assign in_stall = q_full;

  always_comb begin
    keep        = 1'b0;
    q_cmd.kind  = CMD_SAMPLE;
    q_cmd.axis  = in_axis;
    q_cmd.raw   = in_raw_value;
    q_cmd.moving = in_moving;
    q_cmd.stamp = in_stamp;
    case (in_action)
      ACT_SAMPLE: begin
        q_cmd.kind = CMD_SAMPLE;
        keep = (in_axis == AXIS_X) || (in_axis == AXIS_Y) || (in_axis == AXIS_Z);
      end
      ACT_SYNC: begin
        q_cmd.kind = CMD_SYNC;
        keep = 1'b1;
      end
      ACT_RESTART: begin
        q_cmd.kind = CMD_RESTART;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = in_valid && !q_full && keep;

endmodule

// File: rtl/gbc_back.sv
module gbc_back #(
  parameter int CAL_SAMPLES = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gbc_pkg::cfg_t                  cfg,
  input  logic                           q_empty,
  input  gbc_pkg::cmd_t                  q_cmd,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [gbc_pkg::RATE_W-1:0] out_rate_x,
  output logic signed [gbc_pkg::RATE_W-1:0] out_rate_y,
  output logic signed [gbc_pkg::RATE_W-1:0] out_rate_z,
  output logic [gbc_pkg::STAMP_W-1:0]    out_stamp,
  output logic                           out_is_calibrated
);

  import gbc_pkg::*;

  localparam int DIG_W    = 12;
  localparam int NUM_DIG  = SUM_W / DIG_W;
  localparam int DIV_W    = CNT_W + DIG_W;
  localparam int RECIP_SH = DIV_W + CNT_W;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int STEP_W   = $clog2(NUM_DIG);
  localparam logic [CNT_W-1:0] CAL_N = CNT_W'(CAL_SAMPLES);
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** RECIP_SH + CAL_SAMPLES - 1) / CAL_SAMPLES);

  back_state_t               state_r, state_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic [1:0]                axis_r, axis_nxt;
  logic signed [RATE_W-1:0]  held_r [NUM_AXES];
  logic signed [RATE_W-1:0]  held_nxt [NUM_AXES];
  logic signed [SUM_W-1:0]   sum_r [NUM_AXES];
  logic signed [SUM_W-1:0]   sum_nxt [NUM_AXES];
  logic [SUM_W-1:0]          dvd_r [NUM_AXES];
  logic [SUM_W-1:0]          dvd_nxt [NUM_AXES];
  logic [CNT_W-1:0]          rem_r [NUM_AXES];
  logic [CNT_W-1:0]          rem_nxt [NUM_AXES];
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      cal_r, cal_nxt;
  logic [STAMP_W-1:0]        stamp_r, stamp_nxt;
  logic                      emit_r, emit_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [RATE_W-1:0]  out_x_r, out_x_nxt;
  logic signed [RATE_W-1:0]  out_y_r, out_y_nxt;
  logic signed [RATE_W-1:0]  out_z_r, out_z_nxt;
  logic [STAMP_W-1:0]        out_stamp_r, out_stamp_nxt;
  logic                      out_cal_r, out_cal_nxt;

  logic [GAIN_W-1:0]         gain_sel;
  logic signed [SUM_W:0]     acc;
  logic signed [RATE_W-1:0]  sat;
  logic [SUM_W-1:0]          mag [NUM_AXES];
  logic [DIV_W-1:0]          div_in [NUM_AXES];
  logic [DIV_W+RECIP_W-1:0]  div_prod [NUM_AXES];
  logic [DIG_W-1:0]          div_q [NUM_AXES];
  logic [DIV_W-1:0]          div_qn [NUM_AXES];
  logic [NUM_AXES-1:0]       over;
  logic                      out_free;

  assign out_valid         = out_valid_r;
  assign out_rate_x        = out_x_r;
  assign out_rate_y        = out_y_r;
  assign out_rate_z        = out_z_r;
  assign out_stamp         = out_stamp_r;
  assign out_is_calibrated = out_cal_r;
  assign out_free          = !out_valid_r || !out_stall;

  always_comb begin
    case (q_cmd.axis)
      AXIS_X:  gain_sel = cfg.gain_x;
      AXIS_Y:  gain_sel = cfg.gain_y;
      default: gain_sel = cfg.gain_z;
    endcase
  end

  // Offset add in 37 bits, then clamp to the signed 32-bit range.
  always_comb begin
    acc = {{(SUM_W + 1 - PROD_W){prod_r[PROD_W-1]}}, prod_r}
        + (cal_r ? {sum_r[axis_r][SUM_W-1], sum_r[axis_r]} : '0);
    if (acc[SUM_W:RATE_W-1] == '0 || acc[SUM_W:RATE_W-1] == '1) begin
      sat = acc[RATE_W-1:0];
    end else if (acc[SUM_W]) begin
      sat = {1'b1, {(RATE_W - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(RATE_W - 1){1'b1}}};
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      mag[i]      = sum_r[i][SUM_W-1] ? SUM_W'(-sum_r[i]) : SUM_W'(sum_r[i]);
      div_in[i]   = {rem_r[i], dvd_r[i][SUM_W-1 -: DIG_W]};
      div_prod[i] = div_in[i] * RECIP;
      div_q[i]    = div_prod[i][RECIP_SH +: DIG_W];
      div_qn[i]   = {{CNT_W{1'b0}}, div_q[i]} * {{DIG_W{1'b0}}, CAL_N};
      over[i]     = dvd_r[i] > {{(SUM_W - LIMIT_W){1'b0}}, cfg.bias_limit};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    prod_nxt      = prod_r;
    axis_nxt      = axis_r;
    held_nxt      = held_r;
    sum_nxt       = sum_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    count_nxt     = count_r;
    cal_nxt       = cal_r;
    stamp_nxt     = stamp_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_stamp_nxt = out_stamp_r;
    out_cal_nxt   = out_cal_r;
    q_pop         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            CMD_SAMPLE: begin
              prod_nxt  = $signed(q_cmd.raw) * $signed({1'b0, gain_sel});
              axis_nxt  = q_cmd.axis;
              state_nxt = ST_SCALE;
            end
            CMD_SYNC: begin
              stamp_nxt = q_cmd.stamp;
              emit_nxt  = cfg.enable;
              if (!cal_r && !q_cmd.moving && count_r < CAL_N) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                  sum_nxt[i] = sum_r[i] + {{(SUM_W - RATE_W){held_r[i][RATE_W-1]}}, held_r[i]};
                end
                count_nxt = count_r + CNT_W'(1);
              end
              state_nxt = ST_SYNC;
            end
            CMD_RESTART: begin
              for (int i = 0; i < NUM_AXES; i++) begin
                sum_nxt[i] = '0;
              end
              count_nxt = '0;
              cal_nxt   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCALE: begin
        held_nxt[axis_r] = sat;
        state_nxt = ST_IDLE;
      end
      ST_SYNC: begin
        if (!cal_r && count_r == CAL_N) begin
          for (int i = 0; i < NUM_AXES; i++) begin
            dvd_nxt[i] = mag[i];
            rem_nxt[i] = '0;
          end
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end else if (!emit_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = held_r[0];
          out_y_nxt     = held_r[1];
          out_z_nxt     = held_r[2];
          out_stamp_nxt = stamp_r;
          out_cal_nxt   = cal_r;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        // Twelve quotient bits per lane per cycle, from a multiply by the reciprocal of the
        // sample count.
        for (int i = 0; i < NUM_AXES; i++) begin
          rem_nxt[i] = CNT_W'(div_in[i] - div_qn[i]);
          dvd_nxt[i] = {dvd_r[i][SUM_W-DIG_W-1:0], div_q[i]};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(NUM_DIG - 1)) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (|over) begin
          for (int i = 0; i < NUM_AXES; i++) begin
            sum_nxt[i] = '0;
          end
          count_nxt = '0;
          cal_nxt   = 1'b0;
        end else begin
          for (int i = 0; i < NUM_AXES; i++) begin
            sum_nxt[i] = sum_r[i][SUM_W-1] ? $signed(dvd_r[i]) : $signed(SUM_W'(-dvd_r[i]));
          end
          cal_nxt = 1'b1;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!emit_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = held_r[0];
          out_y_nxt     = held_r[1];
          out_z_nxt     = held_r[2];
          out_stamp_nxt = stamp_r;
          out_cal_nxt   = cal_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r      <= prod_nxt;
    axis_r      <= axis_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
    stamp_r     <= stamp_nxt;
    emit_r      <= emit_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_z_r     <= out_z_nxt;
    out_stamp_r <= out_stamp_nxt;
    out_cal_r   <= out_cal_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cal_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        held_r[i] <= '0;
        sum_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cal_r       <= cal_nxt;
      out_valid_r <= out_valid_nxt;
      held_r      <= held_nxt;
      sum_r       <= sum_nxt;
    end
  end

endmodule

// File: rtl/gyro_bias_calibrator.sv
// Gyro bias calibrator. Samples, sync events and restarts enter a small command queue and are
// carried out in order by the back end. A sample is a gain multiply, then an offset add with
// saturation; the back end takes no new command until it is through with the last one. The
// sync that completes a calibration set divides the 36-bit sums by the sample count twelve
// bits a cycle and then checks the offsets against the limit before its word is sent; the
// queue stalls the input once it fills meanwhile. A result waits in the output register
// without blocking later samples. Rates are Q7.24 rad/s; stamps pass through unchanged.
module gyro_bias_calibrator #(
  parameter int CAL_SAMPLES = 10,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_action,
  input  logic [1:0]                        in_axis,
  input  logic signed [gbc_pkg::RAW_W-1:0]  in_raw_value,
  input  logic                              in_moving,
  input  logic [gbc_pkg::STAMP_W-1:0]       in_stamp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [gbc_pkg::RATE_W-1:0] out_rate_x,
  output logic signed [gbc_pkg::RATE_W-1:0] out_rate_y,
  output logic signed [gbc_pkg::RATE_W-1:0] out_rate_z,
  output logic [gbc_pkg::STAMP_W-1:0]       out_stamp,
  output logic                              out_is_calibrated,
  input  logic                              cfg_we,
  input  logic [gbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gbc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import gbc_pkg::*;

  cfg_t               cfg_r;
  logic               q_full;
  logic               q_push;
  cmd_t               push_cmd;
  logic               q_empty;
  logic               q_pop;
  logic [$bits(cmd_t)-1:0] pop_bits;
  cmd_t               pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable     <= 1'b0;
      cfg_r.gain_x     <= GAIN_RESET;
      cfg_r.gain_y     <= GAIN_RESET;
      cfg_r.gain_z     <= GAIN_RESET;
      cfg_r.bias_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:     cfg_r.enable     <= cfg_data[0];
        REG_GAIN_ROLL:  cfg_r.gain_x     <= cfg_data[GAIN_W-1:0];
        REG_GAIN_PITCH: cfg_r.gain_y     <= cfg_data[GAIN_W-1:0];
        REG_GAIN_YAW:   cfg_r.gain_z     <= cfg_data[GAIN_W-1:0];
        REG_BIAS_LIMIT: cfg_r.bias_limit <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gbc_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_axis      (in_axis),
    .in_raw_value (in_raw_value),
    .in_moving    (in_moving),
    .in_stamp     (in_stamp),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  gbc_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_bits),
    .empty     (q_empty)
  );

  assign pop_cmd = cmd_t'(pop_bits);

  gbc_back #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_cmd             (pop_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rate_x        (out_rate_x),
    .out_rate_y        (out_rate_y),
    .out_rate_z        (out_rate_z),
    .out_stamp         (out_stamp),
    .out_is_calibrated (out_is_calibrated)
  );

endmodule
